@@ rtl/core/msot_pkg.sv @@
// ----------------------------------------------------------------------------
// msot_pkg: shared types and constants of the one-shot timer table
// Field widths, opcode and result codes, and sequencer states.
// ----------------------------------------------------------------------------
package msot_pkg;

    localparam int KEY_W         = 16;
    localparam int MS_W          = 20;
    localparam int DIV_W         = 10;
    localparam int OP_W          = 2;
    localparam int KIND_W        = 3;
    localparam int SLOT_W        = 4;
    localparam int ENTRY_W       = KEY_W + MS_W;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 24;
    localparam int MAX_RESULTS   = 16;
    localparam int NUM_SLOTS_DEF = 16;

    localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_ARM    = 2'd0,
        OP_DISARM = 2'd1,
        OP_TICK   = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARMED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_DISARMED  = 3'd2,
        KIND_NOT_ARMED = 3'd3,
        KIND_EXPIRED   = 3'd4,
        KIND_NO_EXPIRY = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TICK,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/msot_ram.sv @@
// ----------------------------------------------------------------------------
// msot_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module msot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/msot_div.sv @@
// ----------------------------------------------------------------------------
// msot_div: restoring divider for milliseconds to ticks
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module msot_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [msot_pkg::MS_W-1:0]  i_dividend,
    input  logic [msot_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [msot_pkg::MS_W-1:0]  o_quot
);
    import msot_pkg::*;

    localparam int CNT_W = $clog2(MS_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MS_W-1:0]  r_quot, n_quot;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_den, n_den;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_quot[MS_W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(MS_W);
            n_quot = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract when it fits
            n_rem  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            n_quot = {r_quot[MS_W-2:0], ge};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

@@ rtl/core/multi_slot_oneshot_timer.sv @@
// ----------------------------------------------------------------------------
// multi_slot_oneshot_timer: table of one-shot timer slots
// Arm, disarm and tick commands over a slot table held in one RAM.
//
//   channel   dir  signals                      contents
//   --------  ---  ---------------------------  --------------------------------
//   s_axis    in   tvalid tready tdata tuser    command: opcode, key, delay_ms
//   m_axis    out  tvalid tready tdata tuser    result: kind, slot, key
//                  tlast                        tlast on the final result
//   cfg       in   i_cfg_wr_en i_cfg_wr_data    delay_divisor, written any edge
//
// Arm, disarm and tick walk all NUM_SLOTS entries through the RAM read
// port, one entry a cycle unless a tick walk holds for the output, then
// give the reply in S_DONE and return to S_IDLE, where the next command
// transfer is taken. In S_DONE, arm also waits for the divider, which
// delivers one quotient bit a cycle. Reserved opcodes skip the walk.
// Reset clears the busy bits, the divisor (to 1) and all handshake state;
// the RAM needs no clearing since only the data of busy entries is used.
// A result waiting on m_axis does not block acceptance of the next command;
// the walk holds in place when a further result must leave and the output
// register is still full.
// ----------------------------------------------------------------------------
module multi_slot_oneshot_timer #(
    parameter int NUM_SLOTS = msot_pkg::NUM_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: delay_divisor
    input  logic                             i_cfg_wr_en,
    input  logic [msot_pkg::DIV_W-1:0]       i_cfg_wr_data,
    // command stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] handler_key, [35:16] delay_ms, [39:36] zero
    input  logic [msot_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [msot_pkg::OP_W-1:0]        s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] slot, [19:4] expired_key, [23:20] zero
    output logic [msot_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] kind
    output logic [msot_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                             m_axis_tlast
);
    import msot_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // map a slot index onto the 4-bit result field (low bits kept)
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    // sequencer and table state
    t_state               r_state, n_state;
    logic [DIV_W-1:0]     r_divisor, n_divisor;
    logic [NUM_SLOTS-1:0] r_busy, n_busy;
    t_op                  r_op, n_op;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_hit_idx, n_hit_idx;
    logic                 r_free_found, n_free_found;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    // one expiry held back until we know whether it is the last
    logic                 r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]     r_pend_idx, n_pend_idx;
    logic [KEY_W-1:0]     r_pend_key, n_pend_key;

    // output register
    logic                 r_out_valid, n_out_valid;
    t_kind                r_out_kind, n_out_kind;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [KEY_W-1:0]     r_out_key, n_out_key;
    logic                 r_out_last, n_out_last;

    // RAM port signals
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]     rd_own;
    logic [MS_W-1:0]      rd_rem;

    // divider
    logic                 div_start;
    logic                 div_busy;
    logic [MS_W-1:0]      div_quot;
    logic [DIV_W-1:0]     div_den;
    logic [MS_W-1:0]      arm_ticks;

    logic                 in_fire;
    logic                 push_ok;
    logic                 last_slot;
    logic [IDX_W-1:0]     next_idx;
    logic                 slot_busy;
    logic                 tick_hit;
    logic                 tick_stall;
    logic [IDX_W-1:0]     tgt_idx;

    assign rd_own    = ram_rdata[ENTRY_W-1:MS_W];
    assign rd_rem    = ram_rdata[MS_W-1:0];
    assign div_den   = (r_divisor == '0) ? DIV_W'(1) : r_divisor;
    assign arm_ticks = (div_quot == '0) ? MS_W'(1) : div_quot;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign push_ok       = !r_out_valid || m_axis_tready;
    assign last_slot     = (r_idx == LAST_IDX);
    assign next_idx      = last_slot ? '0 : r_idx + IDX_W'(1);
    assign slot_busy     = r_busy[r_idx];
    assign tgt_idx       = r_found ? r_hit_idx : r_free_idx;

    // a busy slot going from one to zero expires, within the report budget
    assign tick_hit   = slot_busy && (rd_rem == MS_W'(1)) && (r_cnt != CNT_W'(MAX_RESULTS));
    // an expiry must push out the held one; hold the walk if there is no room
    assign tick_stall = tick_hit && r_pend_valid && !push_ok;

    always_comb begin
        n_state      = r_state;
        n_divisor    = i_cfg_wr_en ? i_cfg_wr_data : r_divisor;
        n_busy       = r_busy;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_found      = r_found;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_key   = r_pend_key;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_key    = r_out_key;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = {rd_own, rd_rem - MS_W'(1)};
        ram_raddr    = '0;
        div_start    = 1'b0;

        case (r_state)
            S_IDLE: begin
                // slot 0 is being read, so the walk starts with its data
                if (in_fire) begin
                    n_op         = t_op'(s_axis_tuser);
                    n_key        = s_axis_tdata[KEY_W-1:0];
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_pend_valid = 1'b0;
                    n_cnt        = '0;
                    case (t_op'(s_axis_tuser))
                        OP_ARM: begin
                            div_start = 1'b1;
                            n_state   = S_SCAN;
                        end
                        OP_DISARM: n_state = S_SCAN;
                        OP_TICK:   n_state = S_TICK;
                        default:   n_state = S_DONE;
                    endcase
                end
            end

            S_SCAN: begin
                // look for the key and for the lowest free slot
                ram_raddr = next_idx;
                if (slot_busy && (rd_own == r_key) && !r_found) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!slot_busy && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                n_idx   = next_idx;
                n_state = last_slot ? S_DONE : S_SCAN;
            end

            S_TICK: begin
                ram_raddr = tick_stall ? r_idx : next_idx;
                if (!tick_stall) begin
                    if (slot_busy && (rd_rem == '0)) begin
                        n_busy[r_idx] = 1'b0;
                    end
                    if (slot_busy && (rd_rem != '0)) begin
                        ram_we = 1'b1;
                    end
                    if (tick_hit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_EXPIRED;
                            n_out_slot  = to_slot(r_pend_idx);
                            n_out_key   = r_pend_key;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_idx;
                        n_pend_key   = rd_own;
                        n_cnt        = r_cnt + CNT_W'(1);
                    end
                    n_idx   = next_idx;
                    n_state = last_slot ? S_DONE : S_TICK;
                end
            end

            S_DONE: begin
                if (push_ok && !((r_op == OP_ARM) && div_busy)) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                    case (r_op)
                        OP_ARM: begin
                            if (r_found || r_free_found) begin
                                // reload or take the slot, owner is the key either way
                                ram_we          = 1'b1;
                                ram_waddr       = tgt_idx;
                                ram_wdata       = {r_key, arm_ticks};
                                n_busy[tgt_idx] = 1'b1;
                                n_out_kind      = KIND_ARMED;
                                n_out_slot      = to_slot(tgt_idx);
                            end else begin
                                n_out_kind = KIND_FULL;
                                n_out_slot = '0;
                            end
                            n_out_key = r_key;
                        end
                        OP_DISARM: begin
                            if (r_found) begin
                                n_busy[r_hit_idx] = 1'b0;
                                n_out_kind        = KIND_DISARMED;
                                n_out_slot        = to_slot(r_hit_idx);
                            end else begin
                                n_out_kind = KIND_NOT_ARMED;
                                n_out_slot = '0;
                            end
                            n_out_key = r_key;
                        end
                        OP_TICK: begin
                            // release the held expiry as the final result
                            if (r_pend_valid) begin
                                n_out_kind = KIND_EXPIRED;
                                n_out_slot = to_slot(r_pend_idx);
                                n_out_key  = r_pend_key;
                            end else begin
                                n_out_kind = KIND_NO_EXPIRY;
                                n_out_slot = '0;
                                n_out_key  = '0;
                            end
                            n_pend_valid = 1'b0;
                        end
                        default: begin
                            n_out_kind = KIND_NO_EXPIRY;
                            n_out_slot = '0;
                            n_out_key  = '0;
                        end
                    endcase
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_divisor    <= DIVISOR_RESET;
            r_busy       <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_divisor    <= n_divisor;
            r_busy       <= n_busy;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_pend_idx <= n_pend_idx;
        r_pend_key <= n_pend_key;
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
    end

    // slot table: {owner key, remaining ticks}
    msot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    msot_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (s_axis_tdata[KEY_W+MS_W-1:KEY_W]),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W - KEY_W){1'b0}}, r_out_key, r_out_slot};
    assign m_axis_tlast  = r_out_last;

    // the table is only written while a command is in progress
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_TICK || r_state == S_DONE))
        else $error("slot table written outside a command");

    // a new command never finds a held expiry or a running divider
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_pend_valid && !div_busy))
        else $error("command accepted with leftover work");

    // the report budget of one tick is never exceeded
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("expiry count above limit");

    // an expiry seen during the walk is held for release
    a_hit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && tick_hit && !tick_stall) |=> r_pend_valid)
        else $error("expiry lost");

    // a stalled walk keeps its place and leaves the table alone
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && tick_stall) |-> (!ram_we && n_idx == r_idx))
        else $error("walk moved while stalled");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the one-shot timer slot table
// Streams arm, disarm, tick and reserved commands under several divisor
// settings. A behavioral copy of the slot table predicts every reply, and
// each output transfer is checked in order against the oldest prediction.
// Both stream sides idle at random. The reply side also stalls once for a
// long stretch so that the block backs up and stalls its command input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msot_pkg::*;

    localparam int NUM_SLOTS      = NUM_SLOTS_DEF;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 21;
    localparam int PHASE_ITEMS    = 31;
    localparam int KEY_POOL       = 12;
    // Arm waits for the divider and is the slowest unstalled command. Allow margin.
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 55;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [MS_W-1:0]  ms;
    } timer_cmd_t;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic              last;
    } timer_reply_t;

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [DIV_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [15:0] handler_key, [35:16] delay_ms, [39:36] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [1:0] opcode
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [3:0] slot, [19:4] expired_key, [23:20] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [2:0] kind
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    multi_slot_oneshot_timer #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    timer_cmd_t   cmd_backlog[$];   // commands waiting for the driver
    timer_reply_t due_replies[$];   // predicted replies, oldest first

    // Predicted copy of the slot table and the divisor register
    logic             slot_armed [NUM_SLOTS] = '{default: 1'b0};
    logic [KEY_W-1:0] slot_key   [NUM_SLOTS];
    logic [MS_W-1:0]  slot_ticks [NUM_SLOTS];
    logic [DIV_W-1:0] model_divisor = DIVISOR_RESET;

    // Divisor settings for the random phases, zero and all-ones among them
    logic [DIV_W-1:0] phase_divisors [5] = '{10'd1000, 10'd0, 10'd1023, 10'd5, 10'd1};

    int  cmds_taken        = 0;
    int  replies_seen      = 0;
    int  fail_count        = 0;
    int  stall_cycles      = 0;
    int  backpressure_left = 0;
    bit  backpressure_done = 1'b0;
    timer_cmd_t   drive_cmd;
    logic steady_run;

    // Suspend idling on both sides for a window of accepted commands
    assign steady_run = (cmds_taken >= 90) && (cmds_taken < 130);

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Predictor: apply one command to the table copy and queue its replies
    // ------------------------------------------------------------------
    function automatic void apply_timer_command(timer_cmd_t cmd);
        int unsigned  eff_div;
        int unsigned  ticks;
        int           hit;
        int           free_slot;
        bit           have_reply;
        timer_reply_t rep;

        hit        = -1;
        free_slot  = -1;
        have_reply = 1'b0;
        rep        = '{KIND_NO_EXPIRY, '0, '0, 1'b1};

        // Lowest busy slot holding the key, and lowest free slot
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_armed[i] && slot_key[i] == cmd.key) hit = i;
            if (!slot_armed[i]) free_slot = i;
        end

        case (cmd.op)
            OP_ARM: begin
                // A zero divisor acts as one; never arm for zero ticks
                eff_div = (model_divisor == '0) ? 1 : int'(model_divisor);
                ticks   = int'(cmd.ms) / eff_div;
                if (ticks == 0) ticks = 1;
                if (hit < 0 && free_slot < 0) begin
                    due_replies.push_back('{KIND_FULL, '0, cmd.key, 1'b1});
                end else begin
                    if (hit < 0) begin
                        hit = free_slot;
                        slot_armed[hit] = 1'b1;
                        slot_key[hit]   = cmd.key;
                    end
                    slot_ticks[hit] = MS_W'(ticks);
                    due_replies.push_back('{KIND_ARMED, SLOT_W'(hit), cmd.key, 1'b1});
                end
            end
            OP_DISARM: begin
                if (hit < 0) begin
                    due_replies.push_back('{KIND_NOT_ARMED, '0, cmd.key, 1'b1});
                end else begin
                    slot_armed[hit] = 1'b0;
                    due_replies.push_back('{KIND_DISARMED, SLOT_W'(hit), cmd.key, 1'b1});
                end
            end
            OP_TICK: begin
                // Walk upward: free slots already at zero, count down the rest.
                // Hold each expiry back one step so the final one gets last.
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_armed[i]) begin
                        if (slot_ticks[i] == '0) begin
                            slot_armed[i] = 1'b0;
                        end else begin
                            slot_ticks[i] = slot_ticks[i] - 1'b1;
                            if (slot_ticks[i] == '0) begin
                                if (have_reply) due_replies.push_back(rep);
                                rep        = '{KIND_EXPIRED, SLOT_W'(i), slot_key[i], 1'b0};
                                have_reply = 1'b1;
                            end
                        end
                    end
                end
                rep.last = 1'b1;
                due_replies.push_back(rep);
            end
            default: begin
                // Reserved opcode: no state change, a bare no-expiry reply
                due_replies.push_back(rep);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command driver: advance on a transfer or an empty slot, idle at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_commands
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (cmd_backlog.size() != 0 &&
                (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
                drive_cmd = cmd_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= drive_cmd.op;
                s_axis_tdata  <= {4'b0, drive_cmd.ms, drive_cmd.key};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command monitor: track divisor writes, predict each accepted command
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : observe_commands
        timer_cmd_t seen;
        if (i_rst_n) begin
            if (i_cfg_wr_en) model_divisor = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                seen.op  = t_op'(s_axis_tuser);
                seen.key = s_axis_tdata[15:0];
                seen.ms  = s_axis_tdata[35:16];
                apply_timer_command(seen);
                cmds_taken <= cmds_taken + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reply ready: random idling, plus one long hold-off to fill the block
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (backpressure_left != 0) begin
            m_axis_tready     <= 1'b0;
            backpressure_left <= backpressure_left - 1;
        end else if (!backpressure_done && replies_seen >= HOLD_AFTER) begin
            m_axis_tready     <= 1'b0;
            backpressure_left <= HOLD_CYCLES;
            backpressure_done <= 1'b1;
        end else begin
            m_axis_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Reply checker: compare each transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_replies
        timer_reply_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            replies_seen <= replies_seen + 1;
            if (due_replies.size() == 0) begin
                note_failure($sformatf("reply %0d unexpected: kind %0d slot %0d key %h last %b",
                    replies_seen, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4],
                    m_axis_tlast));
            end else begin
                want = due_replies.pop_front();
                if (m_axis_tuser !== want.kind || m_axis_tdata[3:0] !== want.slot ||
                    m_axis_tdata[19:4] !== want.key || m_axis_tlast !== want.last) begin
                    note_failure($sformatf(
                        "reply %0d: expected kind %0d slot %0d key %h last %b, got kind %0d slot %0d key %h last %b",
                        replies_seen, want.kind, want.slot, want.key, want.last,
                        m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tlast));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run when no transfer happens for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_cmd(t_op op, logic [KEY_W-1:0] key, logic [MS_W-1:0] ms);
        timer_cmd_t cmd;
        cmd = '{op, key, ms};
        cmd_backlog.push_back(cmd);
    endtask

    // Hold until every command is sent and every reply is back, then let the
    // block settle before touching the divisor
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (cmd_backlog.size() != 0 || s_axis_tvalid || due_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned eff_div;
        int unsigned pick;
        timer_cmd_t  cmd;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset divisor of one
        queue_cmd(OP_ARM,    16'h0000, 20'h00000);  // zero delay rounds up to one tick
        queue_cmd(OP_ARM,    16'hFFFF, 20'hFFFFF);  // longest delay, top key
        queue_cmd(OP_ARM,    16'h0000, 20'h00002);  // reload of an armed key
        queue_cmd(OP_DISARM, 16'h1234, 20'h00000);  // key not armed
        queue_cmd(OP_RSVD,   16'hA5A5, 20'h5A5A5);  // reserved opcode
        queue_cmd(OP_TICK,   16'h0000, 20'h00000);  // count down, nothing expires
        queue_cmd(OP_TICK,   16'h0000, 20'h00000);  // slot 0 expires
        queue_cmd(OP_DISARM, 16'hFFFF, 20'h00000);  // disarm a live slot
        queue_cmd(OP_TICK,   16'h0000, 20'h00000);  // expired slot is freed
        for (int i = 0; i < NUM_SLOTS; i++) begin
            queue_cmd(OP_ARM, KEY_W'(16'h0100 + i), 20'h00001);
        end
        queue_cmd(OP_ARM,    16'hBEEF, 20'h00010);  // table full
        queue_cmd(OP_TICK,   16'h0000, 20'h00000);  // every slot expires at once
        queue_cmd(OP_TICK,   16'h0000, 20'h00000);  // all slots freed
        wait_drained();

        // Random phases, one divisor setting each
        foreach (phase_divisors[p]) begin
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= phase_divisors[p];
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b0;
            eff_div = (phase_divisors[p] == '0) ? 1 : int'(phase_divisors[p]);

            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 38)      cmd.op = OP_ARM;
                else if (pick < 55) cmd.op = OP_DISARM;
                else if (pick < 95) cmd.op = OP_TICK;
                else                cmd.op = OP_RSVD;
                // Mostly a small key pool so reloads and disarms hit live slots
                if ($urandom_range(0, 99) < 80) cmd.key = KEY_W'($urandom_range(0, KEY_POOL - 1));
                else                            cmd.key = KEY_W'($urandom());
                // Mostly delays of a few ticks; rarely anything the field holds
                if ($urandom_range(0, 99) < 8) cmd.ms = MS_W'($urandom());
                else                           cmd.ms = MS_W'($urandom_range(0, eff_div * 6));
                cmd_backlog.push_back(cmd);
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
